// File: hw/rtl/vmt_pkg.sv
`default_nettype none

package vmt_pkg;

	localparam int ELEM_W    = 32;
	localparam int DIM       = 4;
	localparam int NUM_ELEMS = DIM * DIM;
	localparam int IDX_W     = 4;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_XFORM = 1'b1
	} cmd_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} pipe_en_t;

endpackage

`default_nettype wire

// File: hw/rtl/vertex_matrix_transform_top.sv
// Transforms homogeneous vertices by a 4x4 signed fixed-point matrix.
// The input channel (in_valid, in_stall) carries one beat per command. A load
// beat (cmd low) writes element_index of the matrix with element_value and
// gives no result; it affects every vertex beat accepted after it.
// A transform beat (cmd high) carries vert_x..vert_w and yields one output
// beat with out_x..out_w, each a saturated row dot product, and overflow set
// when any component saturated.
// While in_stall is low, one beat of either kind is accepted every cycle. A
// vertex result reaches out_valid via the product, pair and result registers:
// sixteen parallel multipliers read the matrix registers in the accept cycle,
// then one stage adds pairs of products and one adds, shifts and saturates.
// When out_stall is high, the result holds steady and the pipeline fills;
// in_stall rises only once every stage holds a pending vertex, and load
// beats are held off along with vertex beats.
// Reset clears the matrix to zero and empties the pipeline.
`default_nettype none

module vertex_matrix_transform_top #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      cmd,
	input  wire logic [vmt_pkg::IDX_W-1:0] element_index,
	input  wire logic signed [31:0]        element_value,
	input  wire logic signed [31:0]        vert_x,
	input  wire logic signed [31:0]        vert_y,
	input  wire logic signed [31:0]        vert_z,
	input  wire logic signed [31:0]        vert_w,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [31:0]             out_x,
	output logic signed [31:0]             out_y,
	output logic signed [31:0]             out_z,
	output logic signed [31:0]             out_w,
	output logic                           overflow
);

	localparam int DIM = vmt_pkg::DIM;

	vmt_pkg::pipe_en_t en;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              in_acc;
	logic              is_xform;

	vmt_pkg::elem_t    elems [vmt_pkg::NUM_ELEMS];
	vmt_pkg::elem_t    vert  [DIM];
	vmt_pkg::elem_t    results [DIM];
	logic [DIM-1:0]    sats;

	always_comb begin
		en.en_s3 = !valid_s3 || !out_stall;
		en.en_s2 = !valid_s2 || en.en_s3;
		en.en_s1 = !valid_s1 || en.en_s2;
	end

	assign in_stall = !en.en_s1;
	assign in_acc   = in_valid && en.en_s1;
	assign is_xform = (cmd == vmt_pkg::CMD_XFORM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.en_s1) begin
				valid_s1 <= in_valid && is_xform;
			end
			if (en.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	vmt_matrix u_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (in_acc && !is_xform),
		.waddr  (element_index),
		.wdata  (element_value),
		.elems  (elems)
	);

	assign vert[0] = vert_x;
	assign vert[1] = vert_y;
	assign vert[2] = vert_z;
	assign vert[3] = vert_w;

	for (genvar r = 0; r < DIM; r++) begin : g_row
		vmt_pkg::elem_t row_elems [DIM];

		for (genvar c = 0; c < DIM; c++) begin : g_col
			assign row_elems[c] = elems[r * DIM + c];
		end

		vmt_row_dot #(
			.FRAC_BITS (FRAC_BITS)
		) u_row_dot (
			.clk    (clk),
			.en     (en),
			.row    (row_elems),
			.vert   (vert),
			.result (results[r]),
			.sat    (sats[r])
		);
	end

	assign out_valid = valid_s3;
	assign out_x     = results[0];
	assign out_y     = results[1];
	assign out_z     = results[2];
	assign out_w     = results[3];
	assign overflow  = |sats;

endmodule

`default_nettype wire

// File: hw/rtl/vmt_matrix.sv
`default_nettype none

module vmt_matrix (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     we,
	input  wire logic [vmt_pkg::IDX_W-1:0] waddr,
	input  wire vmt_pkg::elem_t           wdata,
	output vmt_pkg::elem_t                elems [vmt_pkg::NUM_ELEMS]
);

	vmt_pkg::elem_t elems_q [vmt_pkg::NUM_ELEMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vmt_pkg::NUM_ELEMS; i++) begin
				elems_q[i] <= '0;
			end
		end else if (we) begin
			elems_q[waddr] <= wdata;
		end
	end

	assign elems = elems_q;

endmodule

`default_nettype wire

// File: hw/rtl/vmt_row_dot.sv
`default_nettype none

module vmt_row_dot #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire vmt_pkg::pipe_en_t en,
	input  wire vmt_pkg::elem_t    row  [vmt_pkg::DIM],
	input  wire vmt_pkg::elem_t    vert [vmt_pkg::DIM],
	output vmt_pkg::elem_t         result,
	output logic                   sat
);

	localparam int PROD_W = vmt_pkg::PROD_W;
	localparam int PAIR_W = vmt_pkg::PAIR_W;
	localparam int SUM_W  = vmt_pkg::SUM_W;
	localparam int ELEM_W = vmt_pkg::ELEM_W;

	logic signed [PROD_W-1:0] prod_s1 [vmt_pkg::DIM];
	logic signed [PAIR_W-1:0] pair_s2 [2];
	vmt_pkg::elem_t           result_s3;
	logic                     sat_s3;

	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  shifted;
	logic                     sat_hi;
	logic                     sat_lo;
	vmt_pkg::elem_t           clamped;

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			for (int c = 0; c < vmt_pkg::DIM; c++) begin
				prod_s1[c] <= PROD_W'(row[c]) * PROD_W'(vert[c]);
			end
		end
		if (en.en_s2) begin
			pair_s2[0] <= PAIR_W'(prod_s1[0]) + PAIR_W'(prod_s1[1]);
			pair_s2[1] <= PAIR_W'(prod_s1[2]) + PAIR_W'(prod_s1[3]);
		end
		if (en.en_s3) begin
			result_s3 <= clamped;
			sat_s3    <= sat_hi | sat_lo;
		end
	end

	always_comb begin
		sum     = SUM_W'(pair_s2[0]) + SUM_W'(pair_s2[1]);
		shifted = sum >>> FRAC_BITS;
		sat_hi  = !shifted[SUM_W-1] && (shifted[SUM_W-2:ELEM_W-1] != '0);
		sat_lo  = shifted[SUM_W-1] && (shifted[SUM_W-2:ELEM_W-1] != '1);
		priority if (sat_hi) begin
			clamped = {1'b0, {(ELEM_W-1){1'b1}}};
		end else if (sat_lo) begin
			clamped = {1'b1, {(ELEM_W-1){1'b0}}};
		end else begin
			clamped = shifted[ELEM_W-1:0];
		end
	end

	assign result = result_s3;
	assign sat    = sat_s3;

endmodule

`default_nettype wire

// File: bench/vmt_xform_checker.sv
`timescale 1ns / 100ps

module vmt_xform_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      cmd,
	input  logic [vmt_pkg::IDX_W-1:0] element_index,
	input  logic signed [31:0]        element_value,
	input  logic signed [31:0]        vert_x,
	input  logic signed [31:0]        vert_y,
	input  logic signed [31:0]        vert_z,
	input  logic signed [31:0]        vert_w,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [31:0]        out_x,
	input  logic signed [31:0]        out_y,
	input  logic signed [31:0]        out_z,
	input  logic signed [31:0]        out_w,
	input  logic                      overflow,
	output int                        errors,
	output int                        pending,
	output int                        loads_seen,
	output int                        vertices_checked,
	output int                        saturated_seen
);

	localparam int DIM       = vmt_pkg::DIM;
	localparam int NUM_ELEMS = vmt_pkg::NUM_ELEMS;

	localparam logic signed [65:0] COMP_MAX = 66'sd2147483647;
	localparam logic signed [65:0] COMP_MIN = -66'sd2147483648;

	typedef struct packed {
		vmt_pkg::elem_t x;
		vmt_pkg::elem_t y;
		vmt_pkg::elem_t z;
		vmt_pkg::elem_t w;
		logic           ovf;
	} xformed_t;

	vmt_pkg::elem_t matrix_copy [NUM_ELEMS];
	xformed_t       expected_q [$];

	function automatic xformed_t transform_vertex(input vmt_pkg::elem_t vx,
			input vmt_pkg::elem_t vy, input vmt_pkg::elem_t vz, input vmt_pkg::elem_t vw);
		vmt_pkg::elem_t     vec [DIM];
		vmt_pkg::elem_t     res [DIM];
		logic signed [65:0] acc;
		logic signed [65:0] a;
		logic signed [65:0] b;
		logic signed [65:0] shifted;
		logic               sat;
		xformed_t           r;
		vec[0] = vx;
		vec[1] = vy;
		vec[2] = vz;
		vec[3] = vw;
		sat = 1'b0;
		for (int row = 0; row < DIM; row++) begin
			acc = '0;
			for (int col = 0; col < DIM; col++) begin
				a = matrix_copy[row * DIM + col];
				b = vec[col];
				acc = acc + a * b;
			end
			shifted = acc >>> FRAC_BITS;
			if (shifted > COMP_MAX) begin
				res[row] = 32'sh7FFF_FFFF;
				sat = 1'b1;
			end else if (shifted < COMP_MIN) begin
				res[row] = 32'sh8000_0000;
				sat = 1'b1;
			end else begin
				res[row] = shifted[31:0];
			end
		end
		r.x = res[0];
		r.y = res[1];
		r.z = res[2];
		r.w = res[3];
		r.ovf = sat;
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		xformed_t exp_beat;
		if (!arst_n) begin
			for (int i = 0; i < NUM_ELEMS; i++) begin
				matrix_copy[i] = '0;
			end
			expected_q.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("output beat with no vertex pending: x=%0d y=%0d z=%0d w=%0d",
						out_x, out_y, out_z, out_w);
					errors++;
				end else begin
					exp_beat = expected_q.pop_front();
					check_field("out_x", exp_beat.x, out_x);
					check_field("out_y", exp_beat.y, out_y);
					check_field("out_z", exp_beat.z, out_z);
					check_field("out_w", exp_beat.w, out_w);
					check_field("overflow", {31'b0, exp_beat.ovf}, {31'b0, overflow});
					vertices_checked++;
				end
			end
			if (in_valid && !in_stall) begin
				if (cmd == vmt_pkg::CMD_LOAD) begin
					matrix_copy[element_index] = element_value;
					loads_seen++;
				end else begin
					exp_beat = transform_vertex(vert_x, vert_y, vert_z, vert_w);
					expected_q.push_back(exp_beat);
					if (exp_beat.ovf) begin
						saturated_seen++;
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

// File: bench/tb_vertex_matrix_transform_top.sv
`timescale 1ns / 100ps

module tb_vertex_matrix_transform_top;

	localparam int             FRAC_BITS  = 16;
	localparam int             NUM_RANDOM = 1500;
	localparam int             IDX_W      = vmt_pkg::IDX_W;
	localparam int             DIM        = vmt_pkg::DIM;
	localparam int             NUM_ELEMS  = vmt_pkg::NUM_ELEMS;
	localparam vmt_pkg::elem_t ONE        = 32'sh0001_0000;
	localparam vmt_pkg::elem_t E_MAX      = 32'sh7FFF_FFFF;
	localparam vmt_pkg::elem_t E_MIN      = 32'sh8000_0000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              cmd;
	logic [IDX_W-1:0]  element_index;
	logic signed [31:0] element_value;
	logic signed [31:0] vert_x;
	logic signed [31:0] vert_y;
	logic signed [31:0] vert_z;
	logic signed [31:0] vert_w;
	logic              out_valid;
	logic              out_stall;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] out_w;
	logic              overflow;

	int errors;
	int pending;
	int loads_seen;
	int vertices_checked;
	int saturated_seen;
	bit no_idle;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	vertex_matrix_transform_top #(
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.element_index(element_index),
		.element_value(element_value),
		.vert_x       (vert_x),
		.vert_y       (vert_y),
		.vert_z       (vert_z),
		.vert_w       (vert_w),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.out_w        (out_w),
		.overflow     (overflow)
	);

	vmt_xform_checker #(
		.FRAC_BITS(FRAC_BITS)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.element_index   (element_index),
		.element_value   (element_value),
		.vert_x          (vert_x),
		.vert_y          (vert_y),
		.vert_z          (vert_z),
		.vert_w          (vert_w),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_x           (out_x),
		.out_y           (out_y),
		.out_z           (out_z),
		.out_w           (out_w),
		.overflow        (overflow),
		.errors          (errors),
		.pending         (pending),
		.loads_seen      (loads_seen),
		.vertices_checked(vertices_checked),
		.saturated_seen  (saturated_seen)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic vmt_pkg::elem_t pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return int'($urandom_range(0, 32'h3FFFF)) - 32'sh2_0000;
		end else if (r < 75) begin
			return int'($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000;
		end else if (r < 90) begin
			return $urandom;
		end
		case ($urandom_range(0, 4))
			0: return E_MAX;
			1: return E_MIN;
			2: return '0;
			3: return -32'sd1;
			default: return ONE;
		endcase
	endfunction

	task automatic send_beat(input vmt_pkg::cmd_t op, input logic [IDX_W-1:0] idx,
			input vmt_pkg::elem_t val, input vmt_pkg::elem_t x, input vmt_pkg::elem_t y,
			input vmt_pkg::elem_t z, input vmt_pkg::elem_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= op;
		element_index <= idx;
		element_value <= val;
		vert_x        <= x;
		vert_y        <= y;
		vert_z        <= z;
		vert_w        <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic load_elem(input logic [IDX_W-1:0] idx, input vmt_pkg::elem_t val);
		send_beat(vmt_pkg::CMD_LOAD, idx, val, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic xform(input vmt_pkg::elem_t x, input vmt_pkg::elem_t y,
			input vmt_pkg::elem_t z, input vmt_pkg::elem_t w);
		send_beat(vmt_pkg::CMD_XFORM, IDX_W'($urandom_range(0, NUM_ELEMS - 1)), $urandom,
			x, y, z, w);
	endtask

	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = vmt_pkg::CMD_LOAD;
		element_index = '0;
		element_value = '0;
		vert_x        = '0;
		vert_y        = '0;
		vert_z        = '0;
		vert_w        = '0;
		no_idle       = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The matrix is all zero after reset, so this vertex must come out as zero.
		xform(32'sd1, 32'sd2, E_MAX, E_MIN);
		for (int d = 0; d < DIM; d++) begin
			load_elem(IDX_W'(d * DIM + d), ONE);
		end
		xform(E_MAX, E_MIN, -32'sd1, ONE);
		for (int c = 0; c < DIM; c++) begin
			load_elem(IDX_W'(c), E_MAX);
		end
		for (int c = 0; c < DIM; c++) begin
			load_elem(IDX_W'(DIM + c), E_MIN);
		end
		// Rows of extremes drive both directions of saturation, while the
		// identity rows below must reach the limits without flagging.
		xform(E_MAX, E_MAX, E_MAX, E_MAX);
		xform(E_MIN, E_MIN, E_MIN, E_MIN);
		// A small negative product has to round toward minus infinity.
		load_elem(IDX_W'(8), -32'sd1);
		xform(32'sd1, '0, '0, '0);
		load_elem(IDX_W'(13), E_MIN);
		xform('0, -32'sd1, '0, '0);

		for (int i = 0; i < NUM_RANDOM; i++) begin
			no_idle = (i % 300) < 40;
			if ($urandom_range(0, 99) < 30) begin
				load_elem(IDX_W'($urandom_range(0, NUM_ELEMS - 1)), pick_value());
			end else begin
				xform(pick_value(), pick_value(), pick_value(), pick_value());
			end
		end
		in_valid <= 1'b0;
		no_idle = 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (10) @(posedge clk);
		$display("Run covered %0d matrix loads and %0d checked vertices, %0d of them saturated.",
			loads_seen, vertices_checked, saturated_seen);
		if (errors == 0) begin
			$display("vertex_matrix_transform_top test passed");
		end else begin
			$display("vertex_matrix_transform_top test failed");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("vertex_matrix_transform_top test failed");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/vmt_pkg.sv
hw/rtl/vmt_matrix.sv
hw/rtl/vmt_row_dot.sv
hw/rtl/vertex_matrix_transform_top.sv
bench/vmt_xform_checker.sv
bench/tb_vertex_matrix_transform_top.sv
